### hw/rtl/ftdt_pkg.sv
// ----------------------------------------------------------------------------
// ftdt_pkg: float to decimal text shared definitions
// Field widths, decode constants, character codes, cell control and the
// controller state type used by the float to decimal text unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ftdt_pkg;

  // request and result payload widths
  localparam int unsigned FLOAT_W      = 32;
  localparam int unsigned CHAR_W       = 8;

  // single precision layout
  localparam int unsigned EXP_W        = 8;
  localparam int unsigned FRAC_FIELD_W = 23;
  localparam int unsigned MANT_W       = FRAC_FIELD_W + 1;

  localparam logic [EXP_W-1:0] EXP_SAT   = EXP_W'(158);  // magnitude >= 2^31
  localparam logic [EXP_W-1:0] EXP_INT   = EXP_W'(150);  // no fraction bits left
  localparam logic [EXP_W-1:0] EXP_SUB_F = EXP_W'(149);  // subnormal fraction shift
  localparam logic [EXP_W-1:0] EXP_ALL   = EXP_W'(255);

  // left shift of the integer part stays below EXP_SAT - EXP_INT
  localparam int unsigned LSH_W = $clog2(int'(EXP_SAT) - int'(EXP_INT));

  // fraction alignment shift, clamped; anything larger only sees a zero fraction
  localparam int unsigned      SH_W   = 6;
  localparam logic [EXP_W-1:0] SH_MAX = EXP_W'((1 << SH_W) - 1);

  // fraction scaling
  localparam int unsigned FRACTION_DIGITS = 2;
  localparam int unsigned FRAC_SCALE      = 10 ** FRACTION_DIGITS;
  localparam int unsigned SCALE_W         = $clog2(FRAC_SCALE);
  localparam int unsigned PROD_W          = MANT_W + SCALE_W;
  localparam int unsigned RND_W           = PROD_W + 1;
  localparam int unsigned FPART_W         = SCALE_W;
  localparam int unsigned DSH_W           = $clog2(SCALE_W + 1);

  // integer part
  localparam int unsigned        INT_W      = 31;
  localparam logic [INT_W-1:0]   INT_SAT    = {INT_W{1'b1}};
  localparam int unsigned        INT_DIGITS = 10;
  localparam int unsigned        CNT_W      = $clog2(INT_W);
  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(INT_W - 1);

  // character sequencing
  localparam int unsigned MAX_CHARS = INT_DIGITS + FRACTION_DIGITS + 2;
  localparam int unsigned POS_W     = $clog2(MAX_CHARS + 1);

  // bcd cell
  localparam int unsigned        DIGIT_W     = 4;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = DIGIT_W'(3);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = DIGIT_W'(9);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ROUND,
    ST_LOAD,
    ST_CONV,
    ST_EMIT
  } ftdt_state_e;

endpackage

`default_nettype wire

### hw/rtl/ftdt_if.sv
// ----------------------------------------------------------------------------
// ftdt_if: float to decimal text channels
// Valid/ready channels for the float request and the character results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftdt_req_if import ftdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLOAT_W-1:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

interface ftdt_res_if import ftdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic              range_error;

  modport source (output valid, output char_code, output last_char, output range_error,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input range_error,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/float_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// float_to_decimal_text_unit: single precision float to decimal ascii text
// Prints one float as [-]integer.fraction, one character per result request.
// ----------------------------------------------------------------------------
// The unit takes one float request at a time and returns its text as 4 to
// 14 character results, most significant first, with last_char on the final
// one and range_error on all of them for NaN, infinity or |x| >= 2^31 (the
// integer part then reads 2147483647 and the fraction zeros). After the accept,
// the scale, round and load states scale, round and align the fraction in
// turn; then the row of bcd digit cells shifts in one bit of the 31-bit
// integer part (and of the fraction) per cycle, then each character goes
// into the output register whenever it is empty or its character is taken.
// The next request is accepted in the cycle after
// the last character is loaded, while that character may still wait there.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_decimal_text_unit import ftdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ftdt_req_if.sink  req_i,
  ftdt_res_if.source res_o
);

  ftdt_state_e state_q, state_d;

  logic       req_ready, accept, emit_load, emit_last;
  cell_ctrl_t cell_ctrl;

  // request decode
  logic                    in_sign;
  logic [EXP_W-1:0]        in_bexp;
  logic [FRAC_FIELD_W-1:0] in_mant;
  logic [MANT_W-1:0]       in_sig;
  logic [EXP_W-1:0]        in_shf;
  logic [EXP_W-1:0]        in_exp_lo;
  logic                    in_err, in_nan, in_neg;
  logic [INT_W-1:0]        in_ipart;
  logic [MANT_W-1:0]       in_frac;
  logic [SH_W-1:0]         in_sh;

  // fraction path
  logic [MANT_W-1:0]  frac_q;
  logic [SH_W-1:0]    sh_q;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [RND_W-1:0]   rnd_q, rnd_d, rnd_shifted;
  logic [DSH_W-1:0]   rnd_sh;
  logic [PROD_W-1:0]  lo_mask, half, unit, rem;
  logic               round_up;
  logic [FPART_W-1:0] fpart;

  // converter row
  logic [INT_W-1:0]         int_sr_q, frac_sr_q;
  logic [CNT_W-1:0]         conv_cnt_q;
  logic [INT_DIGITS:0]      int_carry;
  logic [FRACTION_DIGITS:0] frac_carry;
  logic [DIGIT_W-1:0]       int_dig  [INT_DIGITS];
  logic [DIGIT_W-1:0]       frac_dig [FRACTION_DIGITS];

  // character sequencing
  logic              neg_q, err_q;
  logic [POS_W-1:0]  pos_q, nd, jj, int_sel, frac_sel, total;
  logic [DIGIT_W-1:0] sel_digit;
  logic [CHAR_W-1:0] emit_char;
  logic              all_bcd;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q, out_err_q;

  // --------------------------------------------------------------------------
  // decode
  // --------------------------------------------------------------------------
  always_comb begin
    in_sign   = req_i.float_bits[FLOAT_W-1];
    in_bexp   = req_i.float_bits[FLOAT_W-2 -: EXP_W];
    in_mant   = req_i.float_bits[FRAC_FIELD_W-1:0];
    in_sig    = {(in_bexp != '0), in_mant};
    in_err    = (in_bexp >= EXP_SAT);
    in_nan    = (in_bexp == EXP_ALL) && (in_mant != '0);
    // fraction bit count, only meaningful below EXP_INT
    in_shf    = (in_bexp == '0) ? EXP_SUB_F : EXP_INT - in_bexp;
    in_exp_lo = in_bexp - EXP_INT;
    in_neg    = in_err ? (in_sign && !in_nan) : (in_sign && (in_sig != '0));
    in_ipart  = '0;
    in_frac   = '0;
    if (in_err) begin
      in_ipart = INT_SAT;
    end else if (in_bexp >= EXP_INT) begin
      in_ipart = INT_W'(in_sig) << in_exp_lo[LSH_W-1:0];
    end else begin
      in_ipart = INT_W'(in_sig >> in_shf);
      if (in_shf <= SH_MAX) begin
        in_frac = in_sig & ~({MANT_W{1'b1}} << in_shf);
      end
    end
    in_sh = (in_shf > SH_MAX) ? SH_MAX[SH_W-1:0] : in_shf[SH_W-1:0];
  end

  // --------------------------------------------------------------------------
  // fraction: scale, round to 24 significant bits, align
  // --------------------------------------------------------------------------
  assign prod_d = PROD_W'(frac_q) * PROD_W'(FRAC_SCALE);

  always_comb begin
    rnd_sh = '0;
    for (int j = 1; j <= SCALE_W; j++) begin
      if (prod_q[MANT_W-1+j]) begin
        rnd_sh = DSH_W'(j);
      end
    end
    lo_mask  = ~({PROD_W{1'b1}} << rnd_sh);
    half     = lo_mask ^ (lo_mask >> 1);
    unit     = lo_mask + PROD_W'(1);
    rem      = prod_q & lo_mask;
    // nearest, ties to even
    round_up = (rnd_sh != '0) &&
               ((rem > half) || ((rem == half) && ((prod_q & unit) != '0)));
    rnd_d    = RND_W'(prod_q & ~lo_mask) + (round_up ? RND_W'(unit) : '0);
  end

  always_comb begin
    rnd_shifted = rnd_q >> sh_q;
    fpart = (rnd_shifted >= RND_W'(FRAC_SCALE)) ? FPART_W'(FRAC_SCALE - 1)
                                                 : rnd_shifted[FPART_W-1:0];
  end

  // --------------------------------------------------------------------------
  // bcd cell rows, fed msb first
  // --------------------------------------------------------------------------
  assign int_carry[0]  = int_sr_q[INT_W-1];
  assign frac_carry[0] = frac_sr_q[INT_W-1];

  for (genvar g = 0; g < INT_DIGITS; g++) begin : g_int_cell
    ftdt_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .carry_i (int_carry[g]),
      .carry_o (int_carry[g+1]),
      .digit_o (int_dig[g])
    );
  end

  for (genvar g = 0; g < FRACTION_DIGITS; g++) begin : g_frac_cell
    ftdt_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .carry_i (frac_carry[g]),
      .carry_o (frac_carry[g+1]),
      .digit_o (frac_dig[g])
    );
  end

  // --------------------------------------------------------------------------
  // character select
  // --------------------------------------------------------------------------
  always_comb begin
    nd      = POS_W'(1);
    all_bcd = 1'b1;
    for (int j = 1; j < INT_DIGITS; j++) begin
      if (int_dig[j] != '0) begin
        nd = POS_W'(j + 1);
      end
    end
    for (int j = 0; j < INT_DIGITS; j++) begin
      if (int_dig[j] > DIGIT_MAX) begin
        all_bcd = 1'b0;
      end
    end
    for (int j = 0; j < FRACTION_DIGITS; j++) begin
      if (frac_dig[j] > DIGIT_MAX) begin
        all_bcd = 1'b0;
      end
    end
    jj        = pos_q - POS_W'(neg_q);
    int_sel   = nd - POS_W'(1) - jj;
    frac_sel  = POS_W'(FRACTION_DIGITS) + nd - jj;
    sel_digit = '0;
    if (neg_q && (pos_q == '0)) begin
      emit_char = CHAR_MINUS;
    end else if (jj < nd) begin
      for (int j = 0; j < INT_DIGITS; j++) begin
        if (int_sel == POS_W'(j)) begin
          sel_digit = int_dig[j];
        end
      end
      emit_char = CHAR_ZERO + CHAR_W'(sel_digit);
    end else if (jj == nd) begin
      emit_char = CHAR_DOT;
    end else begin
      for (int j = 0; j < FRACTION_DIGITS; j++) begin
        if (frac_sel == POS_W'(j)) begin
          sel_digit = frac_dig[j];
        end
      end
      emit_char = CHAR_ZERO + CHAR_W'(sel_digit);
    end
    total     = POS_W'(neg_q) + nd + POS_W'(FRACTION_DIGITS + 1);
    emit_last = (pos_q == total - POS_W'(1));
  end

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  always_comb begin
    req_ready = 1'b0;
    cell_ctrl = '0;
    emit_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready       = 1'b1;
        cell_ctrl.clear = req_i.valid;
      end
      ST_CONV: begin
        cell_ctrl.shift = 1'b1;
      end
      ST_EMIT: begin
        emit_load = !out_valid_q || res_o.ready;
      end
      default: begin
      end
    endcase
  end

  assign accept = req_i.valid && req_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCALE;
      end
      ST_SCALE: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_CONV;
      ST_CONV: begin
        if (conv_cnt_q == CNT_LAST) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      conv_cnt_q  <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LOAD) begin
        conv_cnt_q <= '0;
      end else if (state_q == ST_CONV) begin
        conv_cnt_q <= conv_cnt_q + CNT_W'(1);
      end
      if (accept) begin
        pos_q <= '0;
      end else if (emit_load) begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q    <= in_neg;
      err_q    <= in_err;
      frac_q   <= in_frac;
      sh_q     <= in_sh;
      int_sr_q <= in_ipart;
    end else if (state_q == ST_CONV) begin
      int_sr_q <= int_sr_q << 1;
    end
    if (state_q == ST_SCALE) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_ROUND) begin
      rnd_q <= rnd_d;
    end
    if (state_q == ST_LOAD) begin
      frac_sr_q <= INT_W'(fpart);
    end else if (state_q == ST_CONV) begin
      frac_sr_q <= frac_sr_q << 1;
    end
    if (emit_load) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
      out_err_q  <= err_q;
    end
  end

  assign req_i.ready       = req_ready;
  assign res_o.valid       = out_valid_q;
  assign res_o.char_code   = out_char_q;
  assign res_o.last_char   = out_last_q;
  assign res_o.range_error = out_err_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_int_row_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.shift |-> !int_carry[INT_DIGITS])
    else $error("integer digit row overflowed");

  a_frac_row_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.shift |-> !frac_carry[FRACTION_DIGITS])
    else $error("fraction digit row overflowed");

  a_digits_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> all_bcd)
    else $error("non-decimal digit while emitting");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && emit_last) |=> (state_q == ST_IDLE))
    else $error("controller did not return to idle after last character");

endmodule

`default_nettype wire

### hw/rtl/ftdt_bcd_cell.sv
// ----------------------------------------------------------------------------
// ftdt_bcd_cell: one decimal digit of the shift-and-add-3 converter row
// Holds one bcd digit, takes a bit from its lower neighbor and passes the
// overflow bit to its upper neighbor on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ftdt_bcd_cell import ftdt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic               carry_i,
  output logic               carry_o,
  output logic [DIGIT_W-1:0] digit_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d, adj;

  always_comb begin
    adj = (digit_q >= BCD_ADJ_MIN) ? digit_q + BCD_ADJ_ADD : digit_q;
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[DIGIT_W-2:0], carry_i};
    end
  end

  assign carry_o = adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

### bench/float_to_decimal_text_unit_test.sv
// ----------------------------------------------------------------------------
// float_to_decimal_text_unit_test: float to decimal text unit testbench
// Sends float requests, directed corner values first and then random ones,
// with bursty input and a receiver that stalls in phases. Each value's text
// is predicted character by character and checked in order.
// ----------------------------------------------------------------------------
module float_to_decimal_text_unit_test;
  import ftdt_pkg::*;

  localparam int N_RANDOM     = 325;
  localparam int DRAIN_AT     = 180;   // request index that waits for an empty pipe
  localparam int LONG_HOLD_AT = 1200;  // result count that starts the long stall
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 80;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              rerr;
  } text_char_t;

  typedef struct packed {
    logic [FLOAT_W-1:0] bits;
    logic               drain;
  } float_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ftdt_req_if req_if ();
  ftdt_res_if res_if ();

  float_to_decimal_text_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #4 clk_i = ~clk_i;

  float_req_t pending_reqs[$];
  text_char_t chars_due[$];
  int         n_sent;
  int         n_bad = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] round_to_24_bits(input logic [63:0] p);
    int          nbits;
    int          d;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] half;
    nbits = 0;
    for (int i = 0; i < 64; i++) if (p[i]) nbits = i + 1;
    if (nbits <= 24) return p;
    d    = nbits - 24;
    q    = p >> d;
    r    = p & ((64'd1 << d) - 64'd1);
    half = 64'd1 << (d - 1);
    if (r > half || (r == half && q[0])) q = q + 64'd1;
    return q << d;
  endfunction

  function automatic void predict_text(input logic [FLOAT_W-1:0] fbits);
    logic              sgn;
    logic [EXP_W-1:0]  bexp;
    logic [22:0]       mant;
    logic [63:0]       m;
    logic [63:0]       frac;
    logic [63:0]       fpart;
    logic [63:0]       div;
    int unsigned       ipart;
    int unsigned       v;
    logic              rerr;
    logic              neg;
    int                k;
    int                f;
    int unsigned       digs[INT_DIGITS];
    int                nd;
    int                n;
    logic [CHAR_W-1:0] txt[MAX_CHARS];
    sgn   = fbits[31];
    bexp  = fbits[30:23];
    mant  = fbits[22:0];
    rerr  = 1'b0;
    ipart = 0;
    fpart = '0;
    frac  = '0;
    if (bexp >= EXP_SAT) begin
      rerr  = 1'b1;
      ipart = 32'(INT_SAT);
      // a nan never gets a minus sign
      neg   = sgn && !(bexp == EXP_ALL && mant != '0);
    end else begin
      if (bexp == '0) begin
        m = {41'd0, mant};
        k = -149;
      end else begin
        m = {40'd0, 1'b1, mant};
        k = int'(bexp) - 150;
      end
      neg = sgn && (m != '0);
      if (k >= 0) begin
        ipart = 32'(m << k);
      end else begin
        f = -k;
        if (f < 64) begin
          ipart = 32'(m >> f);
          frac  = m & ((64'd1 << f) - 64'd1);
        end else begin
          ipart = 0;
          frac  = m;
        end
        // scaled fraction rounded to single precision, then truncated
        if (frac != '0 && f < 64) fpart = round_to_24_bits(frac * 64'(FRAC_SCALE)) >> f;
        if (fpart >= 64'(FRAC_SCALE)) fpart = 64'(FRAC_SCALE) - 64'd1;
      end
    end
    v  = ipart;
    nd = 0;
    do begin
      digs[nd] = v % 10;
      v        = v / 10;
      nd++;
    end while (v != 0);
    n = 0;
    if (neg) begin
      txt[n] = CHAR_MINUS;
      n++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      txt[n] = CHAR_ZERO + CHAR_W'(digs[i]);
      n++;
    end
    txt[n] = CHAR_DOT;
    n++;
    div = 64'(FRAC_SCALE);
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      div    = div / 64'd10;
      txt[n] = CHAR_ZERO + CHAR_W'((fpart / div) % 64'd10);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      chars_due.push_back('{code: txt[i], last: (i == n - 1), rerr: rerr});
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void queue_float(input logic [FLOAT_W-1:0] bits, input logic drain);
    pending_reqs.push_back('{bits: bits, drain: drain});
  endfunction

  function automatic logic [FLOAT_W-1:0] random_float();
    int                 sel;
    logic [EXP_W-1:0]   e;
    logic [FLOAT_W-1:0] r;
    sel = $urandom_range(0, 99);
    r   = $urandom();
    if (sel < 30) return r;
    else if (sel < 70) e = EXP_W'($urandom_range(100, 157));
    else if (sel < 85) e = EXP_W'($urandom_range(118, 134));   // about 2^-9 .. 2^7
    else if (sel < 90) e = EXP_W'($urandom_range(150, 165));   // around saturation
    else if (sel < 95) e = $urandom_range(0, 1) ? EXP_ALL : '0;
    else e = EXP_W'($urandom_range(80, 99));                   // fraction shift near 64
    return {r[31], e, r[22:0]};
  endfunction

  // ---------------------------------------------------------------- request driver
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.float_bits <= '0;
      burst_left        <= 0;
      gap_left          <= 0;
      n_sent            <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_text(req_if.float_bits);
        n_sent <= n_sent + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          req_if.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && chars_due.size() != 0)) begin
          req_if.valid      <= 1'b1;
          req_if.float_bits <= pending_reqs[0].bits;
          void'(pending_reqs.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 20) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor
  int         hold_cnt;
  int         n_chars;
  logic       long_hold_done;
  logic [7:0] stall_phase;
  text_char_t want;

  task automatic report_mismatch(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready   <= 1'b0;
      hold_cnt       <= 0;
      n_chars        <= 0;
      long_hold_done <= 1'b0;
      stall_phase    <= '0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_chars <= n_chars + 1;
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("unexpected char: code %h last %b err %b",
                                    res_if.char_code, res_if.last_char, res_if.range_error));
        end else begin
          want = chars_due.pop_front();
          if (res_if.char_code !== want.code || res_if.last_char !== want.last ||
              res_if.range_error !== want.rerr) begin
            report_mismatch($sformatf(
              "char %0d mismatch: expected code %h last %b err %b, got code %h last %b err %b",
              n_chars, want.code, want.last, want.rerr,
              res_if.char_code, res_if.last_char, res_if.range_error));
          end
        end
      end
      stall_phase <= stall_phase + 8'd1;
      if (hold_cnt != 0) begin
        res_if.ready <= 1'b0;
        hold_cnt     <= hold_cnt - 1;
      end else if (!long_hold_done && n_chars >= LONG_HOLD_AT) begin
        // long back-pressure while the sender keeps offering
        res_if.ready   <= 1'b0;
        hold_cnt       <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else begin
        case (stall_phase[7:6])
          2'd0: res_if.ready <= 1'b1;
          2'd1: res_if.ready <= 1'($urandom_range(0, 1));
          2'd2: res_if.ready <= (stall_phase[1:0] == 2'd0);
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_ni = 1'b0;

    queue_float(32'h0000_0000, 1'b0);  // zero
    queue_float(32'h8000_0000, 1'b0);  // negative zero, no minus
    queue_float(32'h3F80_0000, 1'b0);  // 1.0
    queue_float(32'hBF80_0000, 1'b0);  // -1.0
    queue_float(32'h3F00_0000, 1'b0);  // 0.5
    queue_float(32'h3C23_D70A, 1'b0);  // 0.01
    queue_float(32'h3D8F_5C29, 1'b0);  // 0.07, leading fraction zero
    queue_float(32'hBA83_126F, 1'b0);  // tiny negative
    queue_float(32'h4043_3333, 1'b0);  // 3.05
    queue_float(32'h3F80_A3D7, 1'b0);  // 1.005
    queue_float(32'h42F6_E979, 1'b0);  // 123.456
    queue_float(32'h3F7F_FFFF, 1'b0);  // just below one
    queue_float(32'h4B00_0000, 1'b0);  // 2^23, no fraction bits
    queue_float(32'h4B7F_FFFF, 1'b0);
    queue_float(32'h4EFF_FFFF, 1'b0);  // largest in range
    queue_float(32'hCEFF_FFFF, 1'b0);
    queue_float(32'h4F00_0000, 1'b0);  // 2^31 saturates
    queue_float(32'hCF00_0000, 1'b0);  // -2^31 saturates with minus
    queue_float(32'h7F80_0000, 1'b0);  // +inf
    queue_float(32'hFF80_0000, 1'b0);  // -inf
    queue_float(32'h7FC0_0000, 1'b0);  // nan
    queue_float(32'hFFFF_FFFF, 1'b0);  // negative nan, no minus
    queue_float(32'h0000_0001, 1'b0);  // smallest subnormal
    queue_float(32'h807F_FFFF, 1'b0);  // negative subnormal
    queue_float(32'h2B80_0000, 1'b0);  // fraction shift 63
    queue_float(32'h2B00_0000, 1'b0);  // fraction shift 64
    for (int i = 0; i < N_RANDOM; i++) queue_float(random_float(), (i == DRAIN_AT));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < 26 + N_RANDOM) @(posedge clk_i);
    while (chars_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_bad == 0 && chars_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
